// ===== hdl/arem_pkg.sv =====
// ----------------------------------------------------------------------------
// arem_pkg
// Shared types and constants of the adjacency row edge merger.
// ----------------------------------------------------------------------------
package arem_pkg;

  // fixed field widths
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned MASK_W   = 12;

  // parameter defaults
  localparam int unsigned TABLE_SIZE_DEF = 4096;
  localparam int unsigned MAX_ROW_DEF    = 64;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_KEY_MASK   = '0;
  localparam logic [MASK_W-1:0]     KEY_MASK_RESET = '1;

  // operation codes on in_tuser
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_END = 1'b1;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_READ,
    ST_ADD_DECIDE,
    ST_ADD_SCAN,
    ST_EMIT
  } state_t;

  // command broadcast to the row cells
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_ACC,
    CELL_SHIFT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t             cmd;
    logic [KEY_W-1:0]      key;
    logic [WEIGHT_W-1:0]   weight;
  } cell_ctl_t;

endpackage

// ===== hdl/arem_cell.sv =====
// ----------------------------------------------------------------------------
// arem_cell
// One row position: holds a key and its summed weight, loads, accumulates
// with saturation, or takes its neighbor's entry when the row shifts out.
// ----------------------------------------------------------------------------
module arem_cell (
  input  logic                             clk,
  input  arem_pkg::cell_ctl_t              ctl,
  input  logic                             sel,
  input  logic [arem_pkg::KEY_W-1:0]       nb_key,
  input  logic [arem_pkg::WEIGHT_W-1:0]    nb_wt,
  output logic [arem_pkg::KEY_W-1:0]       key,
  output logic [arem_pkg::WEIGHT_W-1:0]    wt,
  output logic                             hit
);
  import arem_pkg::*;

  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [WEIGHT_W-1:0] wt_r, wt_nxt;
  logic [WEIGHT_W:0]   sum;

  // saturating accumulate
  assign sum = {1'b0, wt_r} + {1'b0, ctl.weight};

  // next entry
  always_comb begin
    key_nxt = key_r;
    wt_nxt  = wt_r;
    unique case (ctl.cmd)
      CELL_HOLD: ;
      CELL_LOAD: begin
        if (sel) begin
          key_nxt = ctl.key;
          wt_nxt  = ctl.weight;
        end
      end
      CELL_ACC: begin
        if (sel) begin
          wt_nxt = sum[WEIGHT_W] ? '1 : sum[WEIGHT_W-1:0];
        end
      end
      CELL_SHIFT: begin
        key_nxt = nb_key;
        wt_nxt  = nb_wt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    wt_r  <= wt_nxt;
  end

  assign key = key_r;
  assign wt  = wt_r;
  assign hit = sel && (key_r == ctl.key);

endmodule

// ===== hdl/arem_slot_ram.sv =====
// ----------------------------------------------------------------------------
// arem_slot_ram
// Slot table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module arem_slot_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 7
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/adjacency_row_edge_merger_core.sv =====
// ----------------------------------------------------------------------------
// adjacency_row_edge_merger_core
// Merges the edges of one adjacency row by neighbor key, summing weights
// with saturation, and streams the merged row out on an end-row transaction.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_     | slave     | tdata {edge_weight, neighbor_key}, tuser operation
//  out_    | master    | tdata {out_weight, out_key}, tlast last_edge,
//          |           | tuser {overflowed, row_empty}
//  cfg_    | apb slave | key_mask at register 0
//
//  add: the registered slot table read, then the update after it or a row scan
//  a slot taken by another key walks the row one cell a cycle, until a match or the end of the row
//  end-row: one result per cycle, shifted out of the cell chain as out_tready allows
//  after reset a clearing pass over every slot table entry holds in_tready low
//  output data comes straight from the first cell and holds while stalled
// ----------------------------------------------------------------------------
module adjacency_row_edge_merger_core #(
  parameter int unsigned TABLE_SIZE = arem_pkg::TABLE_SIZE_DEF,
  parameter int unsigned MAX_ROW    = arem_pkg::MAX_ROW_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input stream
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [arem_pkg::KEY_W+arem_pkg::WEIGHT_W-1:0] in_tdata, // neighbor_key, edge_weight
  input  logic [0:0]                             in_tuser,        // operation
  // result stream
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [arem_pkg::KEY_W+arem_pkg::WEIGHT_W-1:0] out_tdata, // out_key, out_weight
  output logic                                   out_tlast,
  output logic [1:0]                             out_tuser,       // row_empty, overflowed
  // configuration
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [arem_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input  logic [arem_pkg::CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [arem_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                   cfg_pready
);
  import arem_pkg::*;

  localparam int unsigned SlotW    = $clog2(TABLE_SIZE);
  localparam int unsigned CntW     = $clog2(MAX_ROW + 1);
  localparam int unsigned MaskSpan = 1 << MASK_W;

  state_t                state_r, state_nxt;
  logic [MASK_W-1:0]     key_mask_r;
  logic [CntW-1:0]       count_r, count_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [CntW-1:0]       scan_pos_r, scan_pos_nxt;
  logic [SlotW-1:0]      clr_idx_r, clr_idx_nxt;
  logic [KEY_W-1:0]      item_key_r;
  logic [WEIGHT_W-1:0]   item_wt_r;

  logic                  in_fire, out_fire, cfg_wr;
  logic                  hash_load;
  logic [KEY_W-1:0]      hash_src;
  logic [MASK_W-1:0]     hash_x_nxt, hash_x_r;
  logic [SlotW-1:0]      slot_idx;

  logic                  ram_we, ram_re;
  logic [SlotW-1:0]      ram_waddr;
  logic [CntW-1:0]       ram_wdata, slot_e;
  logic [CntW-1:0]       ram_rdata_w;
  logic                  slot_stale, row_full, row_empty, emit_last;

  cell_ctl_t                           cell_ctl;
  logic [CntW-1:0]                     sel_pos;
  logic [MAX_ROW-1:0]                  cell_sel, cell_hit;
  logic [MAX_ROW-1:0][KEY_W-1:0]       cell_key, nb_key;
  logic [MAX_ROW-1:0][WEIGHT_W-1:0]    cell_wt, nb_wt;
  logic                                any_hit;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_KEY_MASK) ?
                      CFG_DATA_W'(key_mask_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mask_r <= KEY_MASK_RESET;
    end else if (cfg_wr && (cfg_paddr[CFG_ADDR_W-1:2] == REG_KEY_MASK)) begin
      key_mask_r <= cfg_pwdata[MASK_W-1:0];
    end
  end

  // row status
  assign slot_e     = ram_rdata_w;
  assign slot_stale = (slot_e == '0) || (slot_e > count_r);
  assign row_full   = (count_r == CntW'(MAX_ROW));
  assign row_empty  = (count_r == '0);
  assign emit_last  = row_empty || (count_r == CntW'(1));

  // slot index: masked key reduced modulo the table size
  assign hash_x_nxt = hash_src[MASK_W-1:0] & key_mask_r;

  always_ff @(posedge clk) begin
    if (hash_load) begin
      hash_x_r <= hash_x_nxt;
    end
  end

  if (TABLE_SIZE >= MaskSpan) begin : g_hash_direct
    assign slot_idx = SlotW'(hash_x_r);
  end else begin : g_hash_reduce
    // quotient by reciprocal before the quotient register, remainder and fix-up after it
    localparam int unsigned RecipShift = 2 * MASK_W;
    localparam int unsigned Recip      = (1 << RecipShift) / TABLE_SIZE;
    localparam int unsigned RecipW     = $clog2(Recip + 1);
    localparam int unsigned QuotW      = $clog2(MaskSpan / TABLE_SIZE + 1);

    logic [MASK_W+RecipW-1:0] prod;
    logic [QuotW-1:0]         quot_nxt, quot_r;
    logic [MASK_W:0]          qt, rem_raw, rem_fix;

    assign prod     = (MASK_W+RecipW)'(hash_x_nxt) * (MASK_W+RecipW)'(Recip);
    assign quot_nxt = QuotW'(prod >> RecipShift);

    always_ff @(posedge clk) begin
      if (hash_load) begin
        quot_r <= quot_nxt;
      end
    end

    assign qt       = (MASK_W+1)'(quot_r * TABLE_SIZE);
    assign rem_raw  = {1'b0, hash_x_r} - qt;
    assign rem_fix  = (rem_raw >= (MASK_W+1)'(TABLE_SIZE)) ?
                      rem_raw - (MASK_W+1)'(TABLE_SIZE) : rem_raw;
    assign slot_idx = rem_fix[SlotW-1:0];
  end

  // slot table
  arem_slot_ram #(
    .DEPTH (TABLE_SIZE),
    .WIDTH (CntW)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (slot_idx),
    .rd_data (ram_rdata_w)
  );

  // chain of row cells
  for (genvar i = 0; i < MAX_ROW; i++) begin : g_cell
    assign cell_sel[i] = (sel_pos == CntW'(i));

    if (i < MAX_ROW - 1) begin : g_link
      assign nb_key[i] = cell_key[i+1];
      assign nb_wt[i]  = cell_wt[i+1];
    end else begin : g_tail
      assign nb_key[i] = '0;
      assign nb_wt[i]  = '0;
    end

    arem_cell u_cell (
      .clk    (clk),
      .ctl    (cell_ctl),
      .sel    (cell_sel[i]),
      .nb_key (nb_key[i]),
      .nb_wt  (nb_wt[i]),
      .key    (cell_key[i]),
      .wt     (cell_wt[i]),
      .hit    (cell_hit[i])
    );
  end

  assign any_hit = |cell_hit;

  // accepted item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_key_r <= in_tdata[KEY_W-1:0];
      item_wt_r  <= in_tdata[KEY_W+WEIGHT_W-1:KEY_W];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_idx_r == SlotW'(TABLE_SIZE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_tuser[0] == OP_END) ? ST_EMIT : ST_ADD_READ;
        end
      end
      ST_ADD_READ: state_nxt = ST_ADD_DECIDE;
      ST_ADD_DECIDE: begin
        state_nxt = (!slot_stale && !any_hit) ? ST_ADD_SCAN : ST_IDLE;
      end
      ST_ADD_SCAN: begin
        if ((scan_pos_r == count_r) || any_hit) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_fire && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: cell commands, slot table access, counters
  always_comb begin
    cell_ctl.cmd    = CELL_HOLD;
    cell_ctl.key    = item_key_r;
    cell_ctl.weight = item_wt_r;
    sel_pos         = '0;
    count_nxt       = count_r;
    ovf_nxt         = ovf_r;
    scan_pos_nxt    = scan_pos_r;
    clr_idx_nxt     = clr_idx_r;
    ram_we          = 1'b0;
    ram_waddr       = slot_idx;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    hash_load       = 1'b0;
    hash_src        = in_tdata[KEY_W-1:0];
    unique case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_fire) begin
          hash_load = 1'b1;
          if (in_tuser[0] == OP_END) begin
            hash_src = cell_key[0];
          end
        end
      end
      ST_ADD_READ: begin
        ram_re = 1'b1;
      end
      ST_ADD_DECIDE: begin
        if (slot_stale) begin
          // empty or stale slot: append and point the slot at it, or flag overflow if the row is full
          if (row_full) begin
            ovf_nxt = 1'b1;
          end else begin
            cell_ctl.cmd = CELL_LOAD;
            sel_pos      = count_r;
            count_nxt    = count_r + 1'b1;
            ram_we       = 1'b1;
            ram_wdata    = count_r + 1'b1;
          end
        end else begin
          sel_pos = slot_e - 1'b1;
          if (any_hit) begin
            cell_ctl.cmd = CELL_ACC;
          end else begin
            scan_pos_nxt = '0;
          end
        end
      end
      ST_ADD_SCAN: begin
        sel_pos = scan_pos_r;
        if (scan_pos_r == count_r) begin
          // no match in the row: append, slot left alone, or flag overflow if the row is full
          if (row_full) begin
            ovf_nxt = 1'b1;
          end else begin
            cell_ctl.cmd = CELL_LOAD;
            count_nxt    = count_r + 1'b1;
          end
        end else if (any_hit) begin
          cell_ctl.cmd = CELL_ACC;
        end else begin
          scan_pos_nxt = scan_pos_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          if (!row_empty) begin
            // shift the row toward the output and free the slot of the sent key
            cell_ctl.cmd = CELL_SHIFT;
            ram_we       = 1'b1;
            count_nxt    = count_r - 1'b1;
            hash_load    = 1'b1;
            hash_src     = cell_key[1];
          end
          if (emit_last) begin
            ovf_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      count_r    <= '0;
      ovf_r      <= 1'b0;
      scan_pos_r <= '0;
      clr_idx_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      scan_pos_r <= scan_pos_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  // stream ports
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata  = row_empty ? '0 : {cell_wt[0], cell_key[0]};
  assign out_tlast  = emit_last;
  assign out_tuser  = {ovf_r, row_empty};

  // an end-row transaction is answered in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_tuser[0] == OP_END) |=> out_tvalid)
    else $error("end-row not followed by a result");

  // the last result leaves an empty row with the overflow flag cleared
  assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_tlast |=> (count_r == '0) && !ovf_r)
    else $error("row not cleared after its last result");

  // no new item is taken while a row is being sent
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input accepted during row output");

  // the scan never runs past the end of the row
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD_SCAN) |-> (scan_pos_r <= count_r))
    else $error("row scan beyond row length");

endmodule
